// ===== hdl/ppa_pkg.sv =====
`default_nettype none
package ppa_pkg;
  localparam int DirEntries   = 1024;
  localparam int TableCount   = 64;
  localparam int TableEntries = 1024;
  localparam int DirW   = $clog2(DirEntries);
  localparam int SlotW  = $clog2(TableEntries);
  localparam int TblW   = $clog2(TableCount);
  localparam int TaddrW = TblW + SlotW;
  localparam int EntW   = 32;
  localparam int DentW  = 18;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_INFO  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_NO_TBLS = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MAP, S_CLRTAB, S_DRD, S_DCHK, S_ERD, S_ECHK, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clr_step;  // directory clear sweep
    logic map_do;    // decide and perform map (bind / write)
    logic tclr_step; // clear one entry of freshly bound table
    logic dir_rd;    // read directory at scan slot
    logic dir_next;  // advance scan slot
    logic ent_rd;    // read table entry at scan slot
    logic ent_chk;   // evaluate entry
    logic ent_next;  // advance table slot
    logic out_load;  // register result
  } cmd_bus_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic map_bind;  // map bound a table, clear sweep needed
    logic tclr_last;
    logic dir_present;
    logic dir_last;
    logic ent_done;  // item finished by this entry
    logic ent_last;
    logic is_map;
  } sts_bus_t;
endpackage
`default_nettype wire

// ===== hdl/physical_page_allocator_unit.sv =====
`default_nettype none
// Two-level page table frame allocator. One item is taken at a time: map
// writes the entry, and when it binds a new table the new table is cleared
// one entry a cycle. Allocate, free and info walk the directory a slot at a
// time, reading each slot and then checking it, and the table of each present
// slot an entry at a time, reading and then checking each entry through the
// registered-read table RAM; allocate and free stop at their first hit.
// After reset the directory is cleared in a pass before the first item.
module physical_page_allocator_unit
  import ppa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [19:0] frame,
  input  wire logic [19:0] virt_page,
  input  wire logic [11:0] flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [19:0]      out_frame,
  output logic [20:0]      used_pages,
  output logic [20:0]      free_pages
);
  cmd_bus_t cb;
  sts_bus_t sb;

  ppa_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cb, .sb);
  ppa_dp u_dp (.clk, .rst, .cb, .sb, .cmd, .frame, .virt_page, .flags,
    .status, .out_frame, .used_pages, .free_pages);
endmodule
`default_nettype wire

// ===== hdl/ppa_ram.sv =====
`default_nettype none
module ppa_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/ppa_ctrl.sv =====
`default_nettype none
module ppa_ctrl
  import ppa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cmd_bus_t      cb,
  input  wire sts_bus_t sb
);
  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = sb.is_map ? S_MAP : S_DRD;
      S_CLR:    if (sb.clr_last) state_next = S_IDLE;
      S_MAP:    state_next = sb.map_bind ? S_CLRTAB : S_OUT;
      S_CLRTAB: if (sb.tclr_last) state_next = S_OUT;
      S_DRD:    state_next = S_DCHK;
      S_DCHK: begin
        if (sb.dir_present) state_next = S_ERD;
        else if (sb.dir_last) state_next = S_OUT;
        else state_next = S_DRD;
      end
      S_ERD:    state_next = S_ECHK;
      S_ECHK: begin
        if (sb.ent_done) state_next = S_OUT;
        else if (!sb.ent_last) state_next = S_ERD;
        else if (sb.dir_last) state_next = S_OUT;
        else state_next = S_DRD;
      end
      S_OUT:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cb = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cb.load = in_valid;
      S_CLR:    cb.clr_step = 1'b1;
      S_MAP:    cb.map_do = 1'b1;
      S_CLRTAB: cb.tclr_step = 1'b1;
      S_DRD:    cb.dir_rd = 1'b1;
      S_DCHK:   cb.dir_next = !sb.dir_present;
      S_ERD:    cb.ent_rd = 1'b1;
      S_ECHK: begin
        cb.ent_chk  = 1'b1;
        cb.ent_next = !sb.ent_done;
        cb.dir_next = !sb.ent_done && sb.ent_last;
      end
      S_OUT:    cb.out_load = !out_valid || !out_stall;
      default:  cb = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cb.out_load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("item accepted but controller stayed idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ERD) |=> (state == S_ECHK))
    else $error("entry read not followed by check");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
endmodule
`default_nettype wire

// ===== hdl/ppa_dp.sv =====
`default_nettype none
module ppa_dp
  import ppa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_bus_t    cb,
  output sts_bus_t         sb,
  input  wire logic [1:0]  cmd,
  input  wire logic [19:0] frame,
  input  wire logic [19:0] virt_page,
  input  wire logic [11:0] flags,
  output logic [1:0]       status,
  output logic [19:0]      out_frame,
  output logic [20:0]      used_pages,
  output logic [20:0]      free_pages
);
  localparam logic [DirW:0]  DirEnd  = (DirW+1)'(DirEntries - 1);
  localparam logic [SlotW:0] SlotEnd = (SlotW+1)'(TableEntries - 1);

  cmd_t        r_cmd;
  logic [19:0] r_frame;
  logic [19:0] r_vp;
  logic [11:0] r_flags;
  logic [TblW:0]  next_table;
  logic [DirW-1:0]  dslot;   // scan / clear directory slot
  logic [SlotW-1:0] eslot;   // scan / clear table slot
  logic [TblW-1:0]  cur_tbl;
  logic [1:0]  st;
  logic [19:0] ofr;
  logic [20:0] used, freec;

  // directory RAM
  logic             d_we;
  logic [DirW-1:0]  d_waddr, d_raddr;
  logic [DentW-1:0] d_wdata, d_rdata;
  // table RAM
  logic              t_we;
  logic [TaddrW-1:0] t_waddr, t_raddr;
  logic [EntW-1:0]   t_wdata, t_rdata;

  ppa_ram #(.Width(DentW), .Depth(DirEntries)) u_dir (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata));
  ppa_ram #(.Width(EntW), .Depth(TableCount*TableEntries)) u_tab (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata));

  logic [9:0] vd, vs;
  logic       in_range, need_bind, map_write;
  logic [TblW-1:0] dent_tbl, map_tbl;
  logic       e_present, e_alloc, e_done;

  assign vd = r_vp[19:10];
  assign vs = r_vp[9:0];
  assign in_range = ({1'b0, vd} <= 11'(DirEntries - 1)) && ({1'b0, vs} <= 11'(TableEntries - 1));
  // directory read of the map slot was issued on load
  assign need_bind = !d_rdata[0];
  assign dent_tbl  = ({1'b0, d_rdata[DentW-1:12]} >= (DentW-11)'(TableCount)) ? '0 :
                     d_rdata[12+:TblW];
  assign map_tbl   = need_bind ? next_table[TblW-1:0] : dent_tbl;
  assign map_write = in_range && !(need_bind && (next_table >= (TblW+1)'(TableCount)));

  assign e_present = t_rdata[0];
  assign e_alloc   = t_rdata[9];
  always_comb begin
    e_done = 1'b0;
    if (e_present) begin
      if (r_cmd == CMD_ALLOC) e_done = !e_alloc;
      else if (r_cmd == CMD_FREE) e_done = (t_rdata[31:12] == r_frame);
    end
  end

  always_comb begin
    d_we = 1'b0; d_waddr = dslot; d_wdata = '0; d_raddr = dslot;
    t_we = 1'b0; t_waddr = {cur_tbl, eslot}; t_wdata = '0; t_raddr = {cur_tbl, eslot};
    if (cb.load) d_raddr = virt_page[19:10];
    if (cb.clr_step) d_we = 1'b1;
    if (cb.map_do && map_write) begin
      if (need_bind) begin
        d_we = 1'b1; d_waddr = vd;
        d_wdata = {(DentW-12)'(next_table[TblW-1:0]), r_flags};
      end
      t_we = 1'b1; t_waddr = {map_tbl, vs[SlotW-1:0]}; t_wdata = {r_frame, r_flags};
    end
    if (cb.tclr_step) begin
      // keep the new entry; clear the rest
      t_we = (eslot != r_vp[SlotW-1:0]);
    end
    // take the table straight from the directory entry being walked
    if (cb.ent_rd) t_raddr = {dent_tbl, eslot};
    if (cb.ent_chk && e_done) begin
      t_we = 1'b1;
      t_wdata = (r_cmd == CMD_ALLOC) ? (t_rdata | 32'h200) : (t_rdata & ~32'h200);
    end
  end

  always_comb begin
    sb = '0;
    sb.clr_last    = ({1'b0, dslot} == DirEnd);
    sb.map_bind    = map_write && need_bind;
    sb.tclr_last   = ({1'b0, eslot} == SlotEnd);
    sb.dir_present = d_rdata[0];
    sb.dir_last    = ({1'b0, dslot} == DirEnd);
    sb.ent_done    = e_done;
    sb.ent_last    = ({1'b0, eslot} == SlotEnd);
    sb.is_map      = (cmd_t'(cmd) == CMD_MAP);
  end

  always_ff @(posedge clk) begin
    if (cb.load) begin
      r_cmd <= cmd_t'(cmd); r_frame <= frame; r_vp <= virt_page; r_flags <= flags;
      eslot <= '0;
      st <= (cmd_t'(cmd) == CMD_ALLOC || cmd_t'(cmd) == CMD_FREE) ? ST_NONE : ST_OK;
      ofr <= '0; used <= '0; freec <= '0;
    end
    if (rst || cb.load) dslot <= '0;
    else if (cb.clr_step || cb.dir_next) dslot <= dslot + 1'b1;
    if (cb.map_do) begin
      eslot <= '0; cur_tbl <= map_tbl;
      if (in_range && !map_write) st <= ST_NO_TBLS;
    end
    if (cb.tclr_step) eslot <= eslot + 1'b1;
    if (cb.dir_rd) eslot <= '0;
    if (cb.ent_rd && sb.dir_present) cur_tbl <= dent_tbl;
    if (cb.ent_next) eslot <= eslot + 1'b1;
    if (cb.ent_chk) begin
      if (e_done) begin
        st <= ST_OK;
        if (r_cmd == CMD_ALLOC) ofr <= t_rdata[31:12];
      end
      if (r_cmd == CMD_INFO && e_present) begin
        if (e_alloc) used <= used + 1'b1;
        else freec <= freec + 1'b1;
      end
    end
    if (cb.out_load) begin
      status <= st; out_frame <= ofr; used_pages <= used; free_pages <= freec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) next_table <= '0;
    else if (cb.map_do && map_write && need_bind) next_table <= next_table + 1'b1;
  end

  assert property (@(posedge clk) disable iff (rst)
    next_table <= (TblW+1)'(TableCount))
    else $error("table pool overrun");
  assert property (@(posedge clk) disable iff (rst)
    (cb.ent_chk && e_done) |-> (r_cmd == CMD_ALLOC || r_cmd == CMD_FREE))
    else $error("info scan modified an entry");
  assert property (@(posedge clk) disable iff (rst)
    cb.map_do |-> (r_cmd == CMD_MAP))
    else $error("map step on non-map item");
endmodule
`default_nettype wire

// ===== verif/physical_page_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
module physical_page_allocator_unit_tb;
  import ppa_pkg::*;

  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned HoldCycles = 40000;

  typedef struct {
    logic [1:0]  st;
    logic [19:0] fr;
    logic [20:0] used;
    logic [20:0] free_cnt;
  } answer_t;

  typedef struct {
    cmd_t        c;
    logic [19:0] fr;
    logic [19:0] vp;
    logic [11:0] fl;
    bit          fixed;
    answer_t     ans;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [19:0] frame;
  logic [19:0] virt_page;
  logic [11:0] flags;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [19:0] out_frame;
  logic [20:0] used_pages;
  logic [20:0] free_pages;

  physical_page_allocator_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .frame(frame), .virt_page(virt_page), .flags(flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_frame(out_frame),
    .used_pages(used_pages), .free_pages(free_pages)
  );

  // page table mirror
  logic [17:0] pt_dir [DirEntries];
  logic [31:0] pt_mem [TableCount*TableEntries];
  int unsigned pt_next;

  answer_t     pending_answers[$];
  logic [19:0] mapped_frames[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cnt;
  bit          hold_go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic walk_tables(input cmd_t c, input logic [19:0] fr, output answer_t a);
    bit done;
    int unsigned base;
    logic [31:0] e;
    done = 0;
    a = '{default: '0};
    a.st = (c == CMD_INFO) ? ST_OK : ST_NONE;
    for (int d = 0; d < DirEntries && !done; d++) begin
      if (!pt_dir[d][0]) continue;
      base = pt_dir[d][17:12] * TableEntries;
      for (int s = 0; s < TableEntries && !done; s++) begin
        e = pt_mem[base + s];
        if (!e[0]) continue;
        case (c)
          CMD_ALLOC: if (!e[9]) begin
            pt_mem[base + s] = e | 32'h200;
            a.fr = e[31:12];
            a.st = ST_OK;
            done = 1;
          end
          CMD_FREE: if (e[31:12] == fr) begin
            pt_mem[base + s] = e & ~32'h200;
            a.st = ST_OK;
            done = 1;
          end
          default: if (e[9]) a.used++;
          else a.free_cnt++;
        endcase
      end
    end
  endtask

  task automatic predict_page_op(input cmd_t c, input logic [19:0] fr, input logic [19:0] vp,
                                 input logic [11:0] fl, output answer_t a);
    logic [9:0] d;
    logic [9:0] s;
    bit ok;
    a = '{default: '0};
    if (c == CMD_MAP) begin
      d = vp[19:10];
      s = vp[9:0];
      ok = 1;
      if (!pt_dir[d][0]) begin
        if (pt_next >= TableCount) begin
          ok = 0;
          a.st = ST_NO_TBLS;
        end else begin
          pt_dir[d] = {pt_next[5:0], fl};
          for (int i = 0; i < TableEntries; i++) pt_mem[pt_next*TableEntries + i] = '0;
          pt_next++;
        end
      end
      if (ok) pt_mem[pt_dir[d][17:12]*TableEntries + s] = {fr, fl};
    end else begin
      walk_tables(c, fr, a);
    end
  endtask

  task automatic send_item(input cmd_t c, input logic [19:0] fr, input logic [19:0] vp,
                           input logic [11:0] fl, input bit fixed, input answer_t typed);
    answer_t a;
    in_valid  <= 1'b1;
    cmd       <= c;
    frame     <= fr;
    virt_page <= vp;
    flags     <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_page_op(c, fr, vp, fl, a);
    pending_answers.push_back(fixed ? typed : a);
    if (c == CMD_MAP && fl[0] && mapped_frames.size() < 32) mapped_frames.push_back(fr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    answer_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        x = pending_answers.pop_front();
        if (status !== x.st) begin
          $error("status: expected %0d, got %0d", x.st, status);
          errors++;
        end
        if (out_frame !== x.fr) begin
          $error("out_frame: expected %0h, got %0h", x.fr, out_frame);
          errors++;
        end
        if (used_pages !== x.used) begin
          $error("used_pages: expected %0d, got %0d", x.used, used_pages);
          errors++;
        end
        if (free_pages !== x.free_cnt) begin
          $error("free_pages: expected %0d, got %0d", x.free_cnt, free_pages);
          errors++;
        end
      end
    end
    if (hold_go) begin
      hold_go = 0;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  row_t rows[19] = '{
    '{CMD_INFO,  20'h0,     20'h0,     12'h000, 1, '{ST_OK,   20'h0, 21'd0, 21'd0}},
    '{CMD_ALLOC, 20'h0,     20'h0,     12'h000, 1, '{ST_NONE, 20'h0, 21'd0, 21'd0}},
    '{CMD_FREE,  20'hfffff, 20'h0,     12'h000, 1, '{ST_NONE, 20'h0, 21'd0, 21'd0}},
    '{CMD_MAP,   20'hfffff, 20'hfffff, 12'h001, 1, '{ST_OK,   20'h0, 21'd0, 21'd0}},
    '{CMD_MAP,   20'h00000, 20'h00000, 12'hfff, 1, '{ST_OK,   20'h0, 21'd0, 21'd0}},
    '{CMD_MAP,   20'h12345, 20'h00001, 12'h007, 1, '{ST_OK,   20'h0, 21'd0, 21'd0}},
    '{CMD_MAP,   20'h54321, 20'h01403, 12'h000, 1, '{ST_OK,   20'h0, 21'd0, 21'd0}},
    '{CMD_MAP,   20'h0abcd, 20'h01404, 12'h003, 1, '{ST_OK,   20'h0, 21'd0, 21'd0}},
    '{CMD_INFO,  20'h0,     20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_ALLOC, 20'h0,     20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_ALLOC, 20'h0,     20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_ALLOC, 20'h0,     20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_ALLOC, 20'h0,     20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_FREE,  20'h12345, 20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_FREE,  20'h00000, 20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_FREE,  20'h12345, 20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_INFO,  20'h0,     20'h0,     12'h000, 0, '{default: '0}},
    '{CMD_MAP,   20'habcde, 20'h003ff, 12'h201, 0, '{default: '0}},
    '{CMD_ALLOC, 20'h0,     20'h0,     12'h000, 0, '{default: '0}}
  };

  initial begin
    int unsigned pick;
    int unsigned wait_cnt;
    cmd_t c;
    logic [19:0] fr;
    logic [19:0] vp;
    logic [11:0] fl;
    logic [9:0] dslot;
    answer_t none;
    none = '{default: '0};
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    frame = '0;
    virt_page = '0;
    flags = '0;
    out_stall = 1'b0;
    errors = 0;
    cycles = 0;
    hold_cnt = 0;
    hold_go = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < DirEntries; i++) pt_dir[i] = '0;
    pt_next = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_item(rows[i].c, rows[i].fr, rows[i].vp, rows[i].fl, rows[i].fixed, rows[i].ans);

    for (int n = 0; n < 24; n++) begin
      case (n / 6)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // hold the receiver off while items keep coming
      if (n == 12) hold_go = 1;
      pick = $urandom_range(99);
      c = (pick < 40) ? CMD_MAP : (pick < 65) ? CMD_ALLOC : (pick < 85) ? CMD_FREE : CMD_INFO;
      case ($urandom_range(2))
        0: dslot = 10'd0;
        1: dslot = 10'd1023;
        default: dslot = 10'd512;
      endcase
      vp = {dslot, 10'($urandom)};
      fr = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(15));
      if (c == CMD_FREE && mapped_frames.size() > 0 && $urandom_range(9) < 6)
        fr = mapped_frames[$urandom_range(mapped_frames.size() - 1)];
      fl = 12'($urandom);
      if ($urandom_range(9) != 0) fl[0] = 1'b1;
      send_item(c, fr, vp, fl, 0, none);
    end

    // use up the table pool with slots that stay absent, then ask for one more
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; pt_next < TableCount; k++)
      send_item(CMD_MAP, 20'($urandom), {10'(100 + k), 10'($urandom)}, 12'h0fe, 0, none);
    send_item(CMD_MAP, 20'h11111, {10'd900, 10'd7}, 12'h001, 1,
              '{ST_NO_TBLS, 20'h0, 21'd0, 21'd0});
    send_item(CMD_MAP, 20'h22222, {10'd0, 10'd9}, 12'h001, 0, none);
    send_item(CMD_INFO, 20'h0, 20'h0, 12'h0, 0, none);
    send_item(CMD_ALLOC, 20'h0, 20'h0, 12'h0, 0, none);
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending_answers.size() != 0 && wait_cnt < 2000000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
